// ===== hw/rtl/idhs_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the identifier-allocating handle store
// no dependencies; imported by id_allocating_handle_store

package idhs_pkg;

	localparam int HANDLE_W = 32;
	localparam int LEN_W    = 16;
	localparam int FIELD_ID_W = 16;
	localparam int TOTAL_W  = 32;
	localparam int INV_ID   = 0;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_DELETE = 2'd2
	} idhs_mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FREE_SCAN,
		ST_CAND,
		ST_KEY_SCAN,
		ST_FIND,
		ST_DONE
	} idhs_state_t;

	typedef struct packed {
		logic [1:0]            mode;
		logic [FIELD_ID_W-1:0] key_id;
		logic [HANDLE_W-1:0]   handle;
		logic [LEN_W-1:0]      payload_length;
	} idhs_req_t;

	typedef struct packed {
		logic [FIELD_ID_W-1:0] result_id;
		logic                  ok;
		logic [HANDLE_W-1:0]   handle_out;
		logic [TOTAL_W-1:0]    usage_bytes;
		logic [FIELD_ID_W-1:0] next_id_value;
	} idhs_rsp_t;

endpackage

// ===== hw/rtl/idhs_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module idhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/id_allocating_handle_store.sv =====
`timescale 1ns / 1ps
// identifier-allocating handle store: flat table scanned by one shared comparator
// depends on idhs_pkg and idhs_ram
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------
//  request | req_valid | req_stall | req  (idhs_req_t)
//  result  | rsp_valid | rsp_stall | rsp  (idhs_rsp_t)
//
// one request at a time; the table is walked one entry a cycle through the ram read port
// lookup/delete: a walk of the table for the key, then the result is loaded into the output register
// add: a walk for a free slot, then per candidate identifier a candidate step and a walk
// of the keys for that identifier, then the result is loaded into the output register
// after reset a clearing pass over every table entry runs before the first request
// a finished result waits in the output register; the next request is taken meanwhile

module id_allocating_handle_store #(
	parameter int TABLE_DEPTH = 64,
	parameter int ID_BITS     = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  idhs_pkg::idhs_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output idhs_pkg::idhs_rsp_t rsp
);

	import idhs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int IW = AW + 1;
	localparam int KW = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
	localparam longint unsigned SPACE = 64'd1 << ID_BITS;
	localparam int LIMIT = (SPACE < 64'(TABLE_DEPTH + 2)) ? int'(SPACE) : TABLE_DEPTH + 2;
	localparam int TW = $clog2(LIMIT + 1);
	localparam logic [IW-1:0] IDX_END  = IW'(TABLE_DEPTH);
	localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_DEPTH - 1);
	localparam int DW = HANDLE_W + LEN_W;

	typedef logic [ID_BITS-1:0] id_t;

	idhs_state_t state_q, state_nxt;

	logic [IW-1:0]      idx_q;
	logic               pend_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic [AW-1:0]      free_q;
	logic [TW-1:0]      tries_q;
	id_t                counter_q;
	logic [TOTAL_W-1:0] total_q;
	logic               out_valid_q;
	idhs_rsp_t          out_q;

	// request payload and working result
	logic [1:0]          mode_q;
	id_t                 key_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [LEN_W-1:0]    len_q;
	id_t                 res_id_q;
	logic                ok_q;
	logic [HANDLE_W-1:0] res_hnd_q;

	// ram ports
	logic            kwe, dwe;
	logic [AW-1:0]   kwaddr;
	logic [ID_BITS:0] kwdata, krdata;
	logic [DW-1:0]   dwdata, drdata;

	id_t  key_m;
	logic kv_valid;
	logic key_match;
	logic hit, scan_end, out_free, accept;

	assign key_m     = id_t'(req.key_id[KW-1:0]);
	assign kv_valid  = krdata[ID_BITS];
	assign key_match = kv_valid && (krdata[ID_BITS-1:0] == key_q);
	assign scan_end  = !pend_s1 && (idx_q == IDX_END);
	assign hit       = pend_s1 && ((state_q == ST_FREE_SCAN) ? !kv_valid : key_match);
	assign out_free  = !out_valid_q || !rsp_stall;
	assign accept    = req_valid && !req_stall;

	idhs_ram #(.WIDTH(ID_BITS + 1), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (kwe),
		.waddr (kwaddr),
		.wdata (kwdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (krdata)
	);

	idhs_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_data_ram (
		.clk   (clk),
		.we    (dwe),
		.waddr (free_q),
		.wdata (dwdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (drdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (idx_q == IDX_LAST) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (req.mode == MODE_ADD) begin
						state_nxt = ST_FREE_SCAN;
					end else if ((req.mode == MODE_LOOKUP || req.mode == MODE_DELETE)
							&& key_m != id_t'(INV_ID)) begin
						state_nxt = ST_FIND;
					end else begin
						state_nxt = ST_DONE;
					end
				end
			end
			ST_FREE_SCAN: begin
				if (hit) state_nxt = ST_CAND;
				else if (scan_end) state_nxt = ST_DONE;
			end
			ST_CAND: begin
				if (tries_q == TW'(LIMIT)) state_nxt = ST_DONE;
				else if (counter_q != id_t'(INV_ID)) state_nxt = ST_KEY_SCAN;
			end
			ST_KEY_SCAN: begin
				// identifier taken: try the next counter value
				if (hit) state_nxt = ST_CAND;
				else if (scan_end) state_nxt = ST_DONE;
			end
			ST_FIND: begin
				if (hit || scan_end) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// ram writes and request stall
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		kwe       = 1'b0;
		kwaddr    = free_q;
		kwdata    = {1'b1, key_q};
		dwe       = 1'b0;
		dwdata    = {handle_q, len_q};
		case (state_q)
			ST_CLEAR: begin
				kwe    = 1'b1;
				kwaddr = idx_q[AW-1:0];
				kwdata = '0;
			end
			ST_KEY_SCAN: begin
				if (scan_end) begin
					kwe = 1'b1;
					dwe = 1'b1;
				end
			end
			ST_FIND: begin
				if (hit && mode_q == MODE_DELETE) begin
					kwe    = 1'b1;
					kwaddr = rd_idx_s1;
					kwdata = {1'b0, key_q};
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			tries_q     <= '0;
			counter_q   <= id_t'(INV_ID + 1);
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;

			case (state_q)
				ST_CLEAR: begin
					idx_q   <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
					pend_s1 <= 1'b0;
				end
				ST_FREE_SCAN, ST_KEY_SCAN, ST_FIND: begin
					if (hit || scan_end) begin
						idx_q   <= '0;
						pend_s1 <= 1'b0;
					end else if (idx_q != IDX_END) begin
						idx_q   <= idx_q + 1'b1;
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				default: begin
					idx_q   <= '0;
					pend_s1 <= 1'b0;
				end
			endcase

			if (accept) begin
				tries_q <= '0;
			end else if (state_q == ST_CAND && tries_q != TW'(LIMIT)) begin
				tries_q   <= tries_q + 1'b1;
				counter_q <= counter_q + 1'b1;
			end

			if (state_q == ST_KEY_SCAN && scan_end) begin
				total_q <= total_q + TOTAL_W'(len_q);
			end else if (state_q == ST_FIND && hit && mode_q == MODE_DELETE) begin
				total_q <= total_q - TOTAL_W'(drdata[LEN_W-1:0]);
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (pend_s1 || idx_q != IDX_END) begin
			rd_idx_s1 <= idx_q[AW-1:0];
		end
		if (accept) begin
			mode_q    <= req.mode;
			key_q     <= key_m;
			handle_q  <= req.handle;
			len_q     <= req.payload_length;
			res_id_q  <= id_t'(INV_ID);
			ok_q      <= 1'b0;
			res_hnd_q <= '0;
		end
		if (state_q == ST_FREE_SCAN && hit) begin
			free_q <= rd_idx_s1;
		end
		if (state_q == ST_CAND) begin
			key_q <= counter_q;
		end
		if (state_q == ST_KEY_SCAN && scan_end) begin
			res_id_q <= key_q;
			ok_q     <= 1'b1;
		end
		if (state_q == ST_FIND && hit) begin
			res_id_q <= key_q;
			ok_q     <= 1'b1;
			if (mode_q == MODE_LOOKUP) begin
				res_hnd_q <= drdata[DW-1:LEN_W];
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_q.result_id     <= FIELD_ID_W'(res_id_q);
			out_q.ok            <= ok_q;
			out_q.handle_out    <= res_hnd_q;
			out_q.usage_bytes   <= total_q;
			out_q.next_id_value <= FIELD_ID_W'(counter_q);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_END)
		else $error("scan index past table end");

	a_tries_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tries_q <= TW'(LIMIT))
		else $error("candidate count past limit");

	a_ok_id: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && ok_q) |-> res_id_q != id_t'(INV_ID))
		else $error("successful request carries the invalid identifier");

	a_add_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KEY_SCAN && scan_end) |=>
			total_q == $past(total_q) + TOTAL_W'($past(len_q)))
		else $error("byte total not advanced by the added length");

endmodule
